// ----- hw/rtl/olad_pkg.sv -----
`timescale 1ns / 1ps

package olad_pkg;

    localparam int DEPTH     = 16;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int VAL_W     = 32;
    localparam int ENTRIES_W = 5;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;
    localparam int OUT_DATA_W = 40;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_DUMP   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

    // control broadcast to every cell of the row
    typedef struct packed {
        logic                    append;
        logic                    delete_req;
        logic                    rotate;
        logic signed [VAL_W-1:0] key;
    } t_cell_ctrl;

endpackage

// ----- hw/rtl/ordered_list_append_delete_key_unit.sv -----
`timescale 1ns / 1ps

// Ordered list of up to DEPTH signed 32-bit values, held in a row of cells.
// Input channel s_axis: tuser = op (0 append, 1 delete first match, 2 dump),
// tdata = value / key. Output channel m_axis: tuser = status, tdata = item
// and entry count, tlast marks the final result of each request.
// Append and delete finish in the cycle the request is taken; the result
// sits in the output register from that edge. A dump of N entries gives N
// results, one per cycle while the output is not stalled, by rotating the
// row of cells one place per result and reading cell 0; after N rotations
// the row is back in order. A new request is taken only while no dump is
// running and the output register is empty or being drained, so append
// and delete requests go at one per cycle while the output is not stalled,
// and a dump holds off the next request until its last result has been
// registered (a dump of an empty list does not).
// Reset empties the list (entry count to zero); cell contents are not
// cleared, and no request is taken while reset is held. When m_axis_tready
// is low the result holds and s_axis_tready drops until it is taken; a
// running dump pauses without losing entries.
module ordered_list_append_delete_key_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [olad_pkg::VAL_W-1:0]           s_axis_tdata,  // [31:0] value
    input  logic [olad_pkg::OP_W-1:0]            s_axis_tuser,  // [1:0] op
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [olad_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // [31:0] item, [36:32] entries
    output logic [olad_pkg::STATUS_W-1:0]        m_axis_tuser,  // [1:0] status
    output logic                                 m_axis_tlast
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } t_state;

    t_state r_state, n_state;

    logic [olad_pkg::CNT_W-1:0]       r_fill, n_fill;
    logic [olad_pkg::CNT_W-1:0]       r_cnt, n_cnt;
    logic                             r_out_valid, n_out_valid;
    logic [olad_pkg::STATUS_W-1:0]    r_status, n_status;
    logic signed [olad_pkg::VAL_W-1:0] r_item, n_item;
    logic                             r_last, n_last;
    logic [olad_pkg::ENTRIES_W-1:0]   r_entries, n_entries;

    logic                             out_free;
    logic                             accept;
    logic                             found_any;
    olad_pkg::t_cell_ctrl             ctrl;

    logic signed [olad_pkg::VAL_W-1:0] cell_val [olad_pkg::DEPTH];
    logic                              found_chain [olad_pkg::DEPTH+1];

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = i_rst_n && (r_state == S_IDLE) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign found_any     = found_chain[olad_pkg::DEPTH];

    assign ctrl.key        = s_axis_tdata;
    assign ctrl.append     = accept && (s_axis_tuser == olad_pkg::OP_APPEND)
                             && (r_fill != olad_pkg::CNT_W'(olad_pkg::DEPTH));
    assign ctrl.delete_req = accept && (s_axis_tuser == olad_pkg::OP_DELETE);
    assign ctrl.rotate     = (r_state == S_DUMP) && out_free;

    assign found_chain[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < olad_pkg::DEPTH; g++) begin : g_cell
            logic signed [olad_pkg::VAL_W-1:0] next_val;
            if (g < olad_pkg::DEPTH - 1) begin : g_mid
                assign next_val = cell_val[g+1];
            end else begin : g_end
                assign next_val = cell_val[g];
            end
            olad_cell u_cell (
                .i_clk      (i_clk),
                .i_ctrl     (ctrl),
                .i_at_fill  (r_fill == olad_pkg::CNT_W'(g)),
                .i_in_range (r_fill > olad_pkg::CNT_W'(g)),
                .i_is_tail  (r_fill == olad_pkg::CNT_W'(g + 1)),
                .i_found    (found_chain[g]),
                .i_next     (next_val),
                .i_head     (cell_val[0]),
                .o_found    (found_chain[g+1]),
                .o_val      (cell_val[g])
            );
        end
    endgenerate

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_status    = r_status;
        n_item      = r_item;
        n_last      = r_last;
        n_entries   = r_entries;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status = olad_pkg::ST_OK;
                    n_item   = '0;
                    n_last   = 1'b1;
                    n_out_valid = 1'b1;
                    case (s_axis_tuser)
                        olad_pkg::OP_APPEND: begin
                            if (r_fill == olad_pkg::CNT_W'(olad_pkg::DEPTH)) begin
                                n_status = olad_pkg::ST_FULL;
                            end else begin
                                n_fill = r_fill + 1'b1;
                            end
                        end
                        olad_pkg::OP_DELETE: begin
                            if (r_fill == '0) begin
                                n_status = olad_pkg::ST_EMPTY;
                            end else if (found_any) begin
                                n_fill = r_fill - 1'b1;
                            end else begin
                                n_status = olad_pkg::ST_NOTFOUND;
                            end
                        end
                        olad_pkg::OP_DUMP: begin
                            if (r_fill == '0) begin
                                n_status = olad_pkg::ST_EMPTY;
                            end else begin
                                n_out_valid = 1'b0;
                                n_cnt       = '0;
                                n_state     = S_DUMP;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_entries = olad_pkg::ENTRIES_W'(n_fill);
                end
            end
            S_DUMP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = olad_pkg::ST_OK;
                    n_item      = cell_val[0];
                    n_last      = (r_cnt + 1'b1) == r_fill;
                    n_entries   = olad_pkg::ENTRIES_W'(r_fill);
                    n_cnt       = r_cnt + 1'b1;
                    if ((r_cnt + 1'b1) == r_fill) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_item    <= n_item;
        r_last    <= n_last;
        r_entries <= n_entries;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tlast  = r_last;
    assign m_axis_tdata  = {3'b000, r_entries, r_item};

endmodule

// ----- hw/rtl/olad_cell.sv -----
`timescale 1ns / 1ps

module olad_cell (
    input  logic                            i_clk,
    input  olad_pkg::t_cell_ctrl            i_ctrl,
    input  logic                            i_at_fill,
    input  logic                            i_in_range,
    input  logic                            i_is_tail,
    input  logic                            i_found,
    input  logic signed [olad_pkg::VAL_W-1:0] i_next,
    input  logic signed [olad_pkg::VAL_W-1:0] i_head,
    output logic                            o_found,
    output logic signed [olad_pkg::VAL_W-1:0] o_val
);

    logic signed [olad_pkg::VAL_W-1:0] r_val;
    logic signed [olad_pkg::VAL_W-1:0] n_val;
    logic                              match;

    assign match   = i_in_range && (r_val == i_ctrl.key);
    assign o_found = i_found || match;
    assign o_val   = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctrl.append && i_at_fill) begin
            n_val = i_ctrl.key;
        end else if (i_ctrl.delete_req && o_found) begin
            // close the gap: everything from the first match onwards moves down
            n_val = i_next;
        end else if (i_ctrl.rotate) begin
            n_val = i_is_tail ? i_head : i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

// ----- hw/rtl/olad_checker.sv -----
`timescale 1ns / 1ps

module olad_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [olad_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [olad_pkg::STATUS_W-1:0]   m_axis_tuser,
    input logic                            m_axis_tlast
);

    // stalled result must stay up
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // a full report only when every slot is taken
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == olad_pkg::ST_FULL)
        |-> (m_axis_tdata[36:32] == olad_pkg::ENTRIES_W'(olad_pkg::DEPTH)) && m_axis_tlast)
        else $error("full status with free slots");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == olad_pkg::ST_EMPTY)
        |-> (m_axis_tdata[36:32] == '0) && m_axis_tlast)
        else $error("empty status with entries present");

    // only dump results carry an item, and those are always ok
    a_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[31:0] != '0) |-> (m_axis_tuser == olad_pkg::ST_OK))
        else $error("item on a non-ok result");

endmodule

bind ordered_list_append_delete_key_unit olad_checker u_olad_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ----- test/ordered_list_append_delete_key_unit_tb.sv -----
`timescale 1ns / 1ps

module ordered_list_append_delete_key_unit_tb;

    localparam logic [olad_pkg::OP_W-1:0] OP_UNUSED   = 2'd3;
    localparam int                        CYCLE_LIMIT = 200000;
    localparam int                        RAND_ITEMS  = 176;
    localparam int                        QUIET_FROM  = 140;
    localparam int                        SCRIPT_LEN  = 25;

    typedef struct packed {
        logic [olad_pkg::STATUS_W-1:0]  status;
        logic [olad_pkg::VAL_W-1:0]     item;
        logic                           last;
        logic [olad_pkg::ENTRIES_W-1:0] entries;
    } t_list_result;

    // one line of the directed script; count > 1 repeats with value + k * step
    typedef struct {
        logic [olad_pkg::OP_W-1:0]      op;
        logic [olad_pkg::VAL_W-1:0]     value;
        int                             count;
        int                             step;
        bit                             typed;
        logic [olad_pkg::STATUS_W-1:0]  status;
        logic [olad_pkg::ENTRIES_W-1:0] entries;
    } t_script_row;

    logic                            i_clk          = 1'b0;
    logic                            i_rst_n        = 1'b0;
    logic                            s_axis_tvalid  = 1'b0;
    logic                            s_axis_tready;
    logic [olad_pkg::VAL_W-1:0]      s_axis_tdata   = '0;  // [31:0] value
    logic [olad_pkg::OP_W-1:0]       s_axis_tuser   = '0;  // [1:0] op
    logic                            m_axis_tvalid;
    logic                            m_axis_tready  = 1'b1;
    logic [olad_pkg::OUT_DATA_W-1:0] m_axis_tdata;         // [31:0] item, [36:32] entries
    logic [olad_pkg::STATUS_W-1:0]   m_axis_tuser;         // [1:0] status
    logic                            m_axis_tlast;

    logic [olad_pkg::VAL_W-1:0] list_copy [$];
    t_list_result               pending_results [$];
    t_script_row                script_rows [SCRIPT_LEN];

    int mismatches     = 0;
    int cycles         = 0;
    bit quiet          = 1'b0;
    bit src_gaps_on    = 1'b1;
    bit sink_stalls_on = 1'b1;

    ordered_list_append_delete_key_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // apply one request to the local copy of the list and queue its results
    task automatic predict_list(input logic [olad_pkg::OP_W-1:0] op,
                                input logic [olad_pkg::VAL_W-1:0] val);
        t_list_result r;
        int           hit;
        bit           dumped;
        hit    = -1;
        dumped = 1'b0;
        r      = '{status: olad_pkg::ST_OK, item: '0, last: 1'b1, entries: '0};
        case (op)
            olad_pkg::OP_APPEND: begin
                if (list_copy.size() >= olad_pkg::DEPTH)
                    r.status = olad_pkg::ST_FULL;
                else
                    list_copy.push_back(val);
            end
            olad_pkg::OP_DELETE: begin
                if (list_copy.size() == 0) begin
                    r.status = olad_pkg::ST_EMPTY;
                end else begin
                    for (int i = 0; i < list_copy.size() && hit < 0; i++)
                        if (list_copy[i] == val)
                            hit = i;
                    if (hit < 0)
                        r.status = olad_pkg::ST_NOTFOUND;
                    else
                        list_copy.delete(hit);
                end
            end
            olad_pkg::OP_DUMP: begin
                if (list_copy.size() == 0) begin
                    r.status = olad_pkg::ST_EMPTY;
                end else begin
                    dumped = 1'b1;
                    for (int i = 0; i < list_copy.size(); i++) begin
                        r.item    = list_copy[i];
                        r.last    = (i == list_copy.size() - 1);
                        r.entries = olad_pkg::ENTRIES_W'(list_copy.size());
                        pending_results.push_back(r);
                    end
                end
            end
            default: ;
        endcase
        if (!dumped) begin
            r.entries = olad_pkg::ENTRIES_W'(list_copy.size());
            pending_results.push_back(r);
        end
    endtask

    task automatic source_gap();
        if (!quiet && src_gaps_on && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
        end
    endtask

    task automatic send_request(input logic [olad_pkg::OP_W-1:0] op,
                                input logic [olad_pkg::VAL_W-1:0] val,
                                input bit typed,
                                input logic [olad_pkg::STATUS_W-1:0] want_status,
                                input logic [olad_pkg::ENTRIES_W-1:0] want_entries);
        int queued;
        source_gap();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= val;
        do @(posedge i_clk); while (!s_axis_tready);
        queued = pending_results.size();
        predict_list(op, val);
        // hand-written rows replace the computed result, state still follows
        if (typed) begin
            while (pending_results.size() > queued)
                void'(pending_results.pop_back());
            pending_results.push_back('{status: want_status, item: '0, last: 1'b1,
                                        entries: want_entries});
        end
    endtask

    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result status %0d item %h",
                                          m_axis_tuser, m_axis_tdata[31:0]));
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", m_axis_tuser,
                                              want.status));
                if (m_axis_tdata[31:0] !== want.item)
                    report_mismatch($sformatf("item %h, want %h", m_axis_tdata[31:0],
                                              want.item));
                if (m_axis_tlast !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b", m_axis_tlast,
                                              want.last));
                if (m_axis_tdata[36:32] !== want.entries)
                    report_mismatch($sformatf("entries %0d, want %0d",
                                              m_axis_tdata[36:32], want.entries));
            end
        end
    end

    // sink back-pressure, switched on and off in stretches
    initial begin
        int cyc;
        cyc = 0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc % 48 == 0)
                sink_stalls_on = ($urandom_range(0, 2) != 0);
            if (!quiet && sink_stalls_on && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        logic [olad_pkg::OP_W-1:0]  op;
        logic [olad_pkg::VAL_W-1:0] val;
        bit                         growing;
        int                         pick;

        script_rows = '{
            '{olad_pkg::OP_DELETE, 32'd5,         1, 0, 1'b1, olad_pkg::ST_EMPTY,    5'd0},
            '{olad_pkg::OP_DUMP,   32'd0,         1, 0, 1'b1, olad_pkg::ST_EMPTY,    5'd0},
            '{OP_UNUSED,           32'd0,         1, 0, 1'b1, olad_pkg::ST_OK,       5'd0},
            '{olad_pkg::OP_APPEND, 32'h8000_0000, 1, 0, 1'b1, olad_pkg::ST_OK,       5'd1},
            '{olad_pkg::OP_DUMP,   32'd0,         1, 0, 1'b0, olad_pkg::ST_OK,       5'd0},
            // lone entry removed: list must come back empty
            '{olad_pkg::OP_DELETE, 32'h8000_0000, 1, 0, 1'b1, olad_pkg::ST_OK,       5'd0},
            '{olad_pkg::OP_DUMP,   32'd0,         1, 0, 1'b1, olad_pkg::ST_EMPTY,    5'd0},
            '{olad_pkg::OP_APPEND, 32'h7FFF_FFFF, 1, 0, 1'b1, olad_pkg::ST_OK,       5'd1},
            '{olad_pkg::OP_APPEND, 32'h8000_0000, 1, 0, 1'b1, olad_pkg::ST_OK,       5'd2},
            '{olad_pkg::OP_APPEND, 32'h0000_0000, 1, 0, 1'b1, olad_pkg::ST_OK,       5'd3},
            '{olad_pkg::OP_APPEND, 32'hFFFF_FFFF, 1, 0, 1'b1, olad_pkg::ST_OK,       5'd4},
            '{olad_pkg::OP_APPEND, 32'h5555_5555, 1, 0, 1'b1, olad_pkg::ST_OK,       5'd5},
            '{olad_pkg::OP_APPEND, 32'hAAAA_AAAA, 1, 0, 1'b1, olad_pkg::ST_OK,       5'd6},
            '{olad_pkg::OP_APPEND, 32'd7,        10, 1, 1'b0, olad_pkg::ST_OK,       5'd0},
            '{olad_pkg::OP_APPEND, 32'd1,         1, 0, 1'b1, olad_pkg::ST_FULL,     5'd16},
            '{olad_pkg::OP_DUMP,   32'd0,         1, 0, 1'b0, olad_pkg::ST_OK,       5'd0},
            '{olad_pkg::OP_DELETE, 32'd12345,     1, 0, 1'b1, olad_pkg::ST_NOTFOUND, 5'd16},
            '{olad_pkg::OP_DELETE, 32'h7FFF_FFFF, 1, 0, 1'b1, olad_pkg::ST_OK,       5'd15},
            '{olad_pkg::OP_DELETE, 32'd16,        1, 0, 1'b1, olad_pkg::ST_OK,       5'd14},
            '{olad_pkg::OP_APPEND, 32'd0,         1, 0, 1'b1, olad_pkg::ST_OK,       5'd15},
            // duplicate key: only the one nearest the head goes
            '{olad_pkg::OP_DELETE, 32'd0,         1, 0, 1'b1, olad_pkg::ST_OK,       5'd14},
            '{olad_pkg::OP_DUMP,   32'd0,         1, 0, 1'b0, olad_pkg::ST_OK,       5'd0},
            '{OP_UNUSED,           32'hFFFF_FFFF, 1, 0, 1'b1, olad_pkg::ST_OK,       5'd14},
            '{olad_pkg::OP_DUMP,   32'h1234_5678, 1, 0, 1'b0, olad_pkg::ST_OK,       5'd0},
            '{olad_pkg::OP_DELETE, 32'hAAAA_AAAA, 1, 0, 1'b1, olad_pkg::ST_OK,       5'd13}
        };

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script_rows[r])
            for (int k = 0; k < script_rows[r].count; k++)
                send_request(script_rows[r].op,
                             script_rows[r].value
                             + olad_pkg::VAL_W'(k * script_rows[r].step),
                             script_rows[r].typed, script_rows[r].status,
                             script_rows[r].entries);

        growing = 1'b1;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 25 == 0) begin
                growing     = ($urandom_range(0, 1) == 1);
                src_gaps_on = ($urandom_range(0, 2) != 0);
            end
            quiet = (n >= QUIET_FROM);

            pick = $urandom_range(0, 99);
            if (pick < (growing ? 60 : 25))
                op = olad_pkg::OP_APPEND;
            else if (pick < 75)
                op = olad_pkg::OP_DELETE;
            else if (pick < 95)
                op = olad_pkg::OP_DUMP;
            else
                op = OP_UNUSED;

            // small values give duplicates, corners give sign extremes
            case ($urandom_range(0, 9))
                0:       val = (($urandom_range(0, 1) == 1) ? 32'h8000_0000 : 32'h7FFF_FFFF)
                               ^ (($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0);
                1, 2, 3: val = olad_pkg::VAL_W'($urandom_range(0, 7));
                default: val = $urandom;
            endcase
            if (op == olad_pkg::OP_DELETE && list_copy.size() != 0
                && $urandom_range(0, 9) < 7)
                val = list_copy[$urandom_range(0, list_copy.size() - 1)];

            send_request(op, val, 1'b0, olad_pkg::ST_OK, '0);
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
